FILE: rtl/smv_pkg.sv
// ----------------------------------------------------------------------------
// smv_pkg
// Shared types, codes and fixed-point helpers for the coordinate-format
// sparse matrix times vector unit.
// ----------------------------------------------------------------------------
package smv_pkg;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 4;
  localparam int VAL_W   = 32;
  localparam int ACC_W   = 64;
  localparam int SIZE_W  = 5;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_VECTOR = 2'd1;
  localparam logic [OP_W-1:0] OP_MULT   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic [SIZE_W-1:0] MATRIX_SIZE_RESET = 5'd16;

  localparam logic signed [VAL_W-1:0] Q16_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] Q16_MIN = 32'sh8000_0000;
  localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  function automatic logic signed [ACC_W-1:0] sat_add64(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
      return a[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

  // floor shift by 16, then clamp to 32 bits
  function automatic logic signed [VAL_W-1:0] to_q16(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    sh = acc >>> 16;
    if (sh[ACC_W-1:VAL_W-1] == '0 || sh[ACC_W-1:VAL_W-1] == '1) begin
      return sh[VAL_W-1:0];
    end
    return sh[ACC_W-1] ? Q16_MIN : Q16_MAX;
  endfunction

endpackage

FILE: rtl/smv_req_if.sv
// ----------------------------------------------------------------------------
// smv_req_if
// Request channel: operation code, indices and value with valid/ready.
// ----------------------------------------------------------------------------
interface smv_req_if import smv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, op, row_index, col_index, value, input ready);
  modport sink (input valid, op, row_index, col_index, value, output ready);
endinterface

FILE: rtl/smv_res_if.sv
// ----------------------------------------------------------------------------
// smv_res_if
// Result channel: one element of the product vector with valid/ready.
// ----------------------------------------------------------------------------
interface smv_res_if import smv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        result_index;
  logic signed [VAL_W-1:0] result_value;
  logic                    last;
  logic                    overflow;

  modport source (output valid, result_index, result_value, last, overflow, input ready);
  modport sink (input valid, result_index, result_value, last, overflow, output ready);
endinterface

FILE: rtl/smv_entry_mem.sv
// ----------------------------------------------------------------------------
// smv_entry_mem
// Coordinate triple store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module smv_entry_mem import smv_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/smv_mac.sv
// ----------------------------------------------------------------------------
// smv_mac
// Shared multiply-accumulate unit: registered 32x32 product, then a
// saturating 64-bit add onto the registered accumulator operand.
// ----------------------------------------------------------------------------
module smv_mac import smv_pkg::*; (
  input  logic                    clk,
  input  logic                    mul_en,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  input  logic signed [ACC_W-1:0] acc_in,
  output logic signed [ACC_W-1:0] sum
);

  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] acc_q;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod  <= a * b;
      acc_q <= acc_in;
    end
  end

  assign sum = sat_add64(acc_q, prod);

endmodule

FILE: rtl/coo_sparse_matrix_vector_multiply_unit.sv
// ----------------------------------------------------------------------------
// coo_sparse_matrix_vector_multiply_unit
// Sparse matrix held as (row, column, value) triples times a dense vector.
//
// Appends (op 0) and vector writes (op 1) are taken while idle and stream
// back to back. A multiply (op 2) clears the row accumulators, walks the
// stored entries in arrival order through one shared multiplier and one
// accumulator memory, and then emits one result per row. The walk reads
// each entry and its vector element, then multiplies and accumulates it
// if it lies inside the matrix, else skips it; the emit reads each row's
// accumulator and loads the result register, waiting while the result
// side is stalled. n, the row count, is matrix_size clamped to 1..MAX_DIM.
// Requests are not taken during a multiply. No clearing pass after reset.
// ----------------------------------------------------------------------------
module coo_sparse_matrix_vector_multiply_unit import smv_pkg::*; #(
  parameter int MAX_DIM     = 16,
  parameter int MAX_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  smv_req_if.sink           req,
  smv_res_if.source         res
);

  localparam int VW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int NW = $clog2(MAX_DIM + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] IDLE     = 3'd0;
  localparam logic [2:0] WALK_RD  = 3'd1;
  localparam logic [2:0] WALK_VEC = 3'd2;
  localparam logic [2:0] WALK_MUL = 3'd3;
  localparam logic [2:0] WALK_ADD = 3'd4;
  localparam logic [2:0] EMIT_RD  = 3'd5;
  localparam logic [2:0] EMIT_LD  = 3'd6;

  logic [2:0]              state;
  logic [SIZE_W-1:0]       matrix_size;
  logic [NW-1:0]           n_eff;
  logic [NW-1:0]           n_run;
  logic [CW-1:0]           entry_count;
  logic [CW-1:0]           walk_idx;
  logic [VW-1:0]           emit_idx;
  logic                    dropped;

  logic                    accept;
  logic                    do_append;
  entry_t                  wr_entry;
  entry_t                  cur;
  logic                    skip;
  logic                    last_entry;

  logic signed [VAL_W-1:0] vec_mem [MAX_DIM];
  logic [MAX_DIM-1:0]      vec_valid;
  logic signed [VAL_W-1:0] vec_q;
  logic                    vec_q_valid;
  logic signed [VAL_W-1:0] vec_rd;

  logic signed [ACC_W-1:0] acc_mem [MAX_DIM];
  logic [MAX_DIM-1:0]      acc_valid;
  logic signed [ACC_W-1:0] acc_q;
  logic                    acc_q_valid;
  logic signed [ACC_W-1:0] acc_rd;
  logic [VW-1:0]           acc_raddr;
  logic signed [ACC_W-1:0] mac_sum;

  logic                    res_valid;
  logic [IDX_W-1:0]        res_index;
  logic signed [VAL_W-1:0] res_value;
  logic                    res_last;
  logic                    res_overflow;
  logic                    emit_last;
  logic                    emit_load;

  // effective dimension
  always_comb begin
    if (matrix_size == '0) begin
      n_eff = NW'(1);
    end else if (32'(matrix_size) > MAX_DIM) begin
      n_eff = NW'(MAX_DIM);
    end else begin
      n_eff = NW'(matrix_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= MATRIX_SIZE_RESET;
    end else if (cfg_wr_en) begin
      matrix_size <= cfg_wr_data;
    end
  end

  assign req.ready = (state == IDLE);
  assign accept    = req.valid && req.ready;
  assign do_append = accept && req.op == OP_APPEND && req.value != '0 &&
                     entry_count != CW'(MAX_ENTRIES);

  assign wr_entry.row   = req.row_index;
  assign wr_entry.col   = req.col_index;
  assign wr_entry.value = req.value;

  smv_entry_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_entry_mem (
    .clk     (clk),
    .wr_en   (do_append),
    .wr_addr (entry_count[AW-1:0]),
    .wr_data (wr_entry),
    .rd_addr (walk_idx[AW-1:0]),
    .rd_data (cur)
  );

  assign skip       = (32'(cur.row) >= 32'(n_run)) || (32'(cur.col) >= 32'(n_run));
  assign last_entry = (walk_idx + CW'(1)) == entry_count;

  // vector store
  always_ff @(posedge clk) begin
    if (accept && req.op == OP_VECTOR && 32'(req.col_index) < MAX_DIM) begin
      vec_mem[VW'(req.col_index)] <= req.value;
    end
    if (state == WALK_VEC && !skip) begin
      vec_q <= vec_mem[VW'(cur.col)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_valid   <= '0;
      vec_q_valid <= 1'b0;
    end else begin
      if (accept && req.op == OP_VECTOR && 32'(req.col_index) < MAX_DIM) begin
        vec_valid[VW'(req.col_index)] <= 1'b1;
      end
      if (state == WALK_VEC && !skip) begin
        vec_q_valid <= vec_valid[VW'(cur.col)];
      end
    end
  end

  assign vec_rd = vec_q_valid ? vec_q : '0;

  // accumulator store
  assign acc_raddr = (state == WALK_VEC) ? VW'(cur.row) : emit_idx;

  always_ff @(posedge clk) begin
    if (state == WALK_ADD) begin
      acc_mem[VW'(cur.row)] <= mac_sum;
    end
    acc_q <= acc_mem[acc_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid   <= '0;
      acc_q_valid <= 1'b0;
    end else begin
      if (accept && req.op == OP_MULT) begin
        acc_valid <= '0;
      end else if (state == WALK_ADD) begin
        acc_valid[VW'(cur.row)] <= 1'b1;
      end
      acc_q_valid <= acc_valid[acc_raddr];
    end
  end

  assign acc_rd = acc_q_valid ? acc_q : '0;

  smv_mac u_mac (
    .clk    (clk),
    .mul_en (state == WALK_MUL),
    .a      (cur.value),
    .b      (vec_rd),
    .acc_in (acc_rd),
    .sum    (mac_sum)
  );

  // sequencer
  assign emit_last = (32'(emit_idx) + 1) == 32'(n_run);
  assign emit_load = (state == EMIT_LD) && (!res_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      entry_count <= '0;
      dropped     <= 1'b0;
      walk_idx    <= '0;
      emit_idx    <= '0;
      n_run       <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (do_append) begin
            entry_count <= entry_count + CW'(1);
          end
          if (accept && req.op == OP_APPEND && req.value != '0 &&
              entry_count == CW'(MAX_ENTRIES)) begin
            dropped <= 1'b1;
          end
          if (accept && req.op == OP_MULT) begin
            n_run    <= n_eff;
            walk_idx <= '0;
            emit_idx <= '0;
            state    <= (entry_count == '0) ? EMIT_RD : WALK_RD;
          end
        end
        WALK_RD: begin
          state <= WALK_VEC;
        end
        WALK_VEC: begin
          if (skip) begin
            walk_idx <= walk_idx + CW'(1);
            state    <= last_entry ? EMIT_RD : WALK_RD;
          end else begin
            state <= WALK_MUL;
          end
        end
        WALK_MUL: begin
          state <= WALK_ADD;
        end
        WALK_ADD: begin
          walk_idx <= walk_idx + CW'(1);
          state    <= last_entry ? EMIT_RD : WALK_RD;
        end
        EMIT_RD: begin
          state <= EMIT_LD;
        end
        EMIT_LD: begin
          if (emit_load) begin
            if (emit_last) begin
              state <= IDLE;
            end else begin
              emit_idx <= emit_idx + VW'(1);
              state    <= EMIT_RD;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      res_index    <= IDX_W'(emit_idx);
      res_value    <= to_q16(acc_rd);
      res_last     <= emit_last;
      res_overflow <= dropped;
    end
  end

  assign res.valid        = res_valid;
  assign res.result_index = res_index;
  assign res.result_value = res_value;
  assign res.last         = res_last;
  assign res.overflow     = res_overflow;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(entry_count) <= MAX_ENTRIES)
    else $error("entry count beyond store depth");

  a_drop_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(dropped) |-> $past(accept && req.op == OP_APPEND))
    else $error("overflow flag set without an append");

  a_acc_row: assert property (@(posedge clk) disable iff (rst)
    state == WALK_ADD |-> 32'(cur.row) < 32'(n_run))
    else $error("accumulate into a row outside the matrix");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    emit_load && emit_last |-> 32'(emit_idx) + 1 == 32'(n_run))
    else $error("last result not on final row");
`endif

endmodule
